[design/mpsr_pkg.sv]
package mpsr_pkg;

   localparam int FIELD_BITS = 32;
   localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 32'd998244353;
   localparam int SEARCH_LIMIT = 1024;
   localparam int TRY_BITS = 11;
   localparam int OPERAND_STEPS = 32;
   localparam int RCNT_BITS = 6;

   // datapath micro-operations
   localparam logic [4:0] DP_NOP      = 5'd0;
   localparam logic [4:0] DP_LOAD     = 5'd1;
   localparam logic [4:0] DP_RED_STEP = 5'd2;
   localparam logic [4:0] DP_POW_INIT = 5'd3;
   localparam logic [4:0] DP_MUL      = 5'd4;
   localparam logic [4:0] DP_WB_ACC   = 5'd5;
   localparam logic [4:0] DP_WB_BASE  = 5'd6;
   localparam logic [4:0] DP_S_INIT   = 5'd7;
   localparam logic [4:0] DP_S_STEP   = 5'd8;
   localparam logic [4:0] DP_Z_INIT   = 5'd9;
   localparam logic [4:0] DP_Z_NEXT   = 5'd10;
   localparam logic [4:0] DP_Z_FOUND  = 5'd11;
   localparam logic [4:0] DP_C_SET    = 5'd12;
   localparam logic [4:0] DP_T_SET    = 5'd13;
   localparam logic [4:0] DP_R_SET    = 5'd14;
   localparam logic [4:0] DP_I_INIT   = 5'd15;
   localparam logic [4:0] DP_WB_TT    = 5'd16;
   localparam logic [4:0] DP_B_INIT   = 5'd17;
   localparam logic [4:0] DP_WB_B     = 5'd18;
   localparam logic [4:0] DP_MM_I     = 5'd19;
   localparam logic [4:0] DP_WB_C     = 5'd20;
   localparam logic [4:0] DP_WB_T     = 5'd21;
   localparam logic [4:0] DP_WB_R     = 5'd22;
   localparam logic [4:0] DP_FIN_POW  = 5'd23;
   localparam logic [4:0] DP_FIN_ROOT = 5'd24;
   localparam logic [4:0] DP_FIN_NONE = 5'd25;

   // power base sources
   localparam logic [1:0] BASE_N    = 2'd0;
   localparam logic [1:0] BASE_CAND = 2'd1;
   localparam logic [1:0] BASE_Z    = 2'd2;

   // power exponent sources
   localparam logic [2:0] EXP_IN   = 3'd0;
   localparam logic [2:0] EXP_P4   = 3'd1;
   localparam logic [2:0] EXP_PM1H = 3'd2;
   localparam logic [2:0] EXP_Q    = 3'd3;
   localparam logic [2:0] EXP_QH   = 3'd4;

   // multiplier operand sources
   localparam logic [2:0] MSRC_ACC  = 3'd0;
   localparam logic [2:0] MSRC_BASE = 3'd1;
   localparam logic [2:0] MSRC_TT   = 3'd2;
   localparam logic [2:0] MSRC_B    = 3'd3;
   localparam logic [2:0] MSRC_C    = 3'd4;
   localparam logic [2:0] MSRC_T    = 3'd5;
   localparam logic [2:0] MSRC_R    = 3'd6;

   // root sources
   localparam logic [1:0] ROOT_ZERO = 2'd0;
   localparam logic [1:0] ROOT_ACC  = 2'd1;
   localparam logic [1:0] ROOT_R    = 2'd2;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] base_sel;
      logic [2:0] exp_sel;
      logic [2:0] ma_sel;
      logic [2:0] mb_sel;
      logic [1:0] root_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic red_done;
      logic p_lt2;
      logic p_mod4_3;
      logic op_sqrt;
      logic n_zero;
      logic e_zero;
      logic e_lsb;
      logic mul_done;
      logic mul_eq_n;
      logic q_even_nz;
      logic cand_ok;
      logic acc_eq_pm1;
      logic t_zero;
      logic t_one;
      logic tt_one;
      logic i_lt_mm;
      logic j_cond;
   } dp_sts_type;

endpackage

[design/mpsr_mulmod.sv]
module mpsr_mulmod #(
   parameter int PW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [PW-1:0] a,
   input  logic [PW-1:0] b,
   input  logic [PW-1:0] m,
   output logic          done,
   output logic [PW-1:0] y
);

   logic          busy_ff, busy_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] aa_ff, aa_in;
   logic [PW-1:0] bb_ff, bb_in;

   // modular add for operands below m
   function automatic logic [PW-1:0] add_m(input logic [PW-1:0] x, input logic [PW-1:0] z,
                                          input logic [PW-1:0] mm);
      logic [PW-1:0] gap;
      gap = mm - z;
      return (x >= gap) ? (x - gap) : (x + z);
   endfunction

   assign done = busy_ff && (bb_ff == '0);
   assign y    = acc_ff;

   // shift-and-add, one multiplier bit per cycle
   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      aa_in   = aa_ff;
      bb_in   = bb_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         aa_in   = a;
         bb_in   = b;
      end else if (busy_ff) begin
         if (bb_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (bb_ff[0]) acc_in = add_m(acc_ff, aa_ff, m);
            aa_in = add_m(aa_ff, aa_ff, m);
            bb_in = bb_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      aa_ff  <= aa_in;
      bb_ff  <= bb_in;
   end

endmodule

[design/mpsr_dp.sv]
module mpsr_dp #(
   parameter int MOD_BITS = 32,
   parameter int EXP_BITS = 63
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mpsr_pkg::dp_cmd_type                  cmd,
   output mpsr_pkg::dp_sts_type                  sts,
   input  logic                                  csr_valid,
   input  logic [mpsr_pkg::FIELD_BITS-1:0]       csr_data,
   input  logic                                  req_op,
   input  logic [mpsr_pkg::FIELD_BITS-1:0]       req_operand,
   input  logic [EXP_BITS-1:0]                   req_exponent,
   output logic [mpsr_pkg::FIELD_BITS-1:0]       rsp_value,
   output logic [mpsr_pkg::FIELD_BITS-1:0]       rsp_other_root,
   output logic [1:0]                            rsp_root_count,
   output logic                                  rsp_no_root
);

   localparam int PW = (MOD_BITS < mpsr_pkg::FIELD_BITS) ? MOD_BITS : mpsr_pkg::FIELD_BITS;
   localparam int EW = (EXP_BITS > PW) ? EXP_BITS : PW;
   localparam int CW = $clog2(PW + 1);
   localparam int FB = mpsr_pkg::FIELD_BITS;
   localparam int RB = mpsr_pkg::RCNT_BITS;
   localparam int TB = mpsr_pkg::TRY_BITS;

   logic [FB-1:0] mod_ff;
   logic [PW-1:0] p_ff, p_in;
   logic          op_ff, op_in;
   logic [FB-1:0] sh_ff, sh_in;
   logic [RB-1:0] rcnt_ff, rcnt_in;
   logic [PW-1:0] n_ff, n_in, acc_ff, acc_in, base_ff, base_in;
   logic [EW-1:0] e_ff, e_in;
   logic [CW-1:0] s_ff, s_in, mm_ff, mm_in, i_ff, i_in, j_ff, j_in;
   logic [PW-1:0] q_ff, q_in, z_ff, z_in, cand_ff, cand_in;
   logic [TB-1:0] tries_ff, tries_in;
   logic [PW-1:0] c_ff, c_in, t_ff, t_in, r_ff, r_in, tt_ff, tt_in, b_ff, b_in;
   logic [FB-1:0] val_ff, val_in, oth_ff, oth_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          none_ff, none_in;

   logic          mul_start, mul_done;
   logic [PW-1:0] mul_a, mul_b, mul_y;
   logic [PW:0]   red_sum;
   logic [PW-1:0] pow_base, root, neg;
   logic [EW-1:0] pow_exp;
   logic [CW:0]   j_sum;

   function automatic logic [PW-1:0] msrc(input logic [2:0] sel, input logic [PW-1:0] acc,
                                          input logic [PW-1:0] base, input logic [PW-1:0] tt,
                                          input logic [PW-1:0] b, input logic [PW-1:0] c,
                                          input logic [PW-1:0] t, input logic [PW-1:0] r);
      logic [PW-1:0] v;
      case (sel)
         mpsr_pkg::MSRC_ACC:  v = acc;
         mpsr_pkg::MSRC_BASE: v = base;
         mpsr_pkg::MSRC_TT:   v = tt;
         mpsr_pkg::MSRC_B:    v = b;
         mpsr_pkg::MSRC_C:    v = c;
         mpsr_pkg::MSRC_T:    v = t;
         mpsr_pkg::MSRC_R:    v = r;
         default:             v = acc;
      endcase
      return v;
   endfunction

   assign mul_start = (cmd.op == mpsr_pkg::DP_MUL);
   assign mul_a = msrc(cmd.ma_sel, acc_ff, base_ff, tt_ff, b_ff, c_ff, t_ff, r_ff);
   assign mul_b = msrc(cmd.mb_sel, acc_ff, base_ff, tt_ff, b_ff, c_ff, t_ff, r_ff);

   mpsr_mulmod #(.PW(PW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .m     (p_ff),
      .done  (mul_done),
      .y     (mul_y)
   );

   // operand reduction step: shift in one operand bit, fold below p
   assign red_sum = {n_ff, sh_ff[FB-1]};

   always_comb begin
      case (cmd.base_sel)
         mpsr_pkg::BASE_N:    pow_base = n_ff;
         mpsr_pkg::BASE_CAND: pow_base = cand_ff;
         mpsr_pkg::BASE_Z:    pow_base = z_ff;
         default:             pow_base = n_ff;
      endcase
      case (cmd.exp_sel)
         mpsr_pkg::EXP_IN:   pow_exp = e_ff;
         mpsr_pkg::EXP_P4:   pow_exp = EW'((p_ff >> 2) + PW'(1));
         mpsr_pkg::EXP_PM1H: pow_exp = EW'((p_ff - PW'(1)) >> 1);
         mpsr_pkg::EXP_Q:    pow_exp = EW'(q_ff);
         mpsr_pkg::EXP_QH:   pow_exp = EW'((q_ff >> 1) + PW'(1));
         default:            pow_exp = e_ff;
      endcase
      case (cmd.root_sel)
         mpsr_pkg::ROOT_ZERO: root = '0;
         mpsr_pkg::ROOT_ACC:  root = acc_ff;
         mpsr_pkg::ROOT_R:    root = r_ff;
         default:             root = '0;
      endcase
      neg = (root == '0) ? '0 : (p_ff - root);
   end

   // execute the micro-operation
   always_comb begin
      p_in = p_ff; op_in = op_ff; sh_in = sh_ff; rcnt_in = rcnt_ff;
      n_in = n_ff; acc_in = acc_ff; base_in = base_ff; e_in = e_ff;
      s_in = s_ff; mm_in = mm_ff; i_in = i_ff; j_in = j_ff;
      q_in = q_ff; z_in = z_ff; cand_in = cand_ff; tries_in = tries_ff;
      c_in = c_ff; t_in = t_ff; r_in = r_ff; tt_in = tt_ff; b_in = b_ff;
      val_in = val_ff; oth_in = oth_ff; cnt_in = cnt_ff; none_in = none_ff;
      case (cmd.op)
         mpsr_pkg::DP_LOAD: begin
            p_in    = PW'(mod_ff);
            op_in   = req_op;
            sh_in   = req_operand;
            rcnt_in = '0;
            n_in    = '0;
            e_in    = EW'(req_exponent);
         end
         mpsr_pkg::DP_RED_STEP: begin
            n_in    = (red_sum >= {1'b0, p_ff}) ? PW'(red_sum - {1'b0, p_ff}) : PW'(red_sum);
            sh_in   = sh_ff << 1;
            rcnt_in = rcnt_ff + RB'(1);
         end
         mpsr_pkg::DP_POW_INIT: begin
            acc_in  = PW'(1);
            base_in = pow_base;
            e_in    = pow_exp;
         end
         mpsr_pkg::DP_WB_ACC:  acc_in = mul_y;
         mpsr_pkg::DP_WB_BASE: begin
            base_in = mul_y;
            e_in    = e_ff >> 1;
         end
         mpsr_pkg::DP_S_INIT: begin
            s_in = '0;
            q_in = p_ff - PW'(1);
         end
         mpsr_pkg::DP_S_STEP: begin
            q_in = q_ff >> 1;
            s_in = s_ff + CW'(1);
         end
         mpsr_pkg::DP_Z_INIT: begin
            z_in     = '0;
            cand_in  = PW'(2);
            tries_in = '0;
         end
         mpsr_pkg::DP_Z_NEXT: begin
            cand_in  = cand_ff + PW'(1);
            tries_in = tries_ff + TB'(1);
         end
         mpsr_pkg::DP_Z_FOUND: z_in = cand_ff;
         mpsr_pkg::DP_C_SET: begin
            c_in  = acc_ff;
            mm_in = s_ff;
         end
         mpsr_pkg::DP_T_SET: t_in = acc_ff;
         mpsr_pkg::DP_R_SET: r_in = acc_ff;
         mpsr_pkg::DP_I_INIT: begin
            i_in  = '0;
            tt_in = t_ff;
         end
         mpsr_pkg::DP_WB_TT: begin
            tt_in = mul_y;
            i_in  = i_ff + CW'(1);
         end
         mpsr_pkg::DP_B_INIT: begin
            b_in = c_ff;
            j_in = '0;
         end
         mpsr_pkg::DP_WB_B: begin
            b_in = mul_y;
            j_in = j_ff + CW'(1);
         end
         mpsr_pkg::DP_MM_I: mm_in = i_ff;
         mpsr_pkg::DP_WB_C: c_in = mul_y;
         mpsr_pkg::DP_WB_T: t_in = mul_y;
         mpsr_pkg::DP_WB_R: r_in = mul_y;
         mpsr_pkg::DP_FIN_POW: begin
            val_in  = FB'(acc_ff);
            oth_in  = '0;
            cnt_in  = 2'd1;
            none_in = 1'b0;
         end
         mpsr_pkg::DP_FIN_ROOT: begin
            val_in  = FB'(root);
            oth_in  = FB'(neg);
            cnt_in  = (root == neg) ? 2'd1 : 2'd2;
            none_in = 1'b0;
         end
         mpsr_pkg::DP_FIN_NONE: begin
            val_in  = '0;
            oth_in  = '0;
            cnt_in  = 2'd0;
            none_in = 1'b1;
         end
         default: ;
      endcase
   end

   // status back to the controller
   assign j_sum = {1'b0, j_ff} + {1'b0, i_ff} + (CW+1)'(1);

   always_comb begin
      sts.red_done   = (rcnt_ff == RB'(mpsr_pkg::OPERAND_STEPS));
      sts.p_lt2      = (p_ff < PW'(2));
      sts.p_mod4_3   = (p_ff[1:0] == 2'b11);
      sts.op_sqrt    = op_ff;
      sts.n_zero     = (n_ff == '0);
      sts.e_zero     = (e_ff == '0);
      sts.e_lsb      = e_ff[0];
      sts.mul_done   = mul_done;
      sts.mul_eq_n   = (mul_y == n_ff);
      sts.q_even_nz  = !q_ff[0] && (q_ff != '0);
      sts.cand_ok    = (cand_ff < p_ff) && (tries_ff < TB'(mpsr_pkg::SEARCH_LIMIT));
      sts.acc_eq_pm1 = (acc_ff == (p_ff - PW'(1)));
      sts.t_zero     = (t_ff == '0);
      sts.t_one      = (t_ff == PW'(1));
      sts.tt_one     = (tt_ff == PW'(1));
      sts.i_lt_mm    = (i_ff < mm_ff);
      sts.j_cond     = (j_sum < {1'b0, mm_ff});
   end

   assign rsp_value      = val_ff;
   assign rsp_other_root = oth_ff;
   assign rsp_root_count = cnt_ff;
   assign rsp_no_root    = none_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= mpsr_pkg::MODULUS_RESET;
      end else if (csr_valid) begin
         mod_ff <= csr_data;
      end
      p_ff <= p_in; op_ff <= op_in; sh_ff <= sh_in; rcnt_ff <= rcnt_in;
      n_ff <= n_in; acc_ff <= acc_in; base_ff <= base_in; e_ff <= e_in;
      s_ff <= s_in; mm_ff <= mm_in; i_ff <= i_in; j_ff <= j_in;
      q_ff <= q_in; z_ff <= z_in; cand_ff <= cand_in; tries_ff <= tries_in;
      c_ff <= c_in; t_ff <= t_in; r_ff <= r_in; tt_ff <= tt_in; b_ff <= b_in;
      val_ff <= val_in; oth_ff <= oth_in; cnt_ff <= cnt_in; none_ff <= none_in;
   end

endmodule

[design/mpsr_ctrl.sv]
module mpsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output mpsr_pkg::dp_cmd_type cmd,
   input  mpsr_pkg::dp_sts_type sts
);

   localparam logic [5:0] S_IDLE  = 6'd0;
   localparam logic [5:0] S_RED   = 6'd1;
   localparam logic [5:0] S_DISP  = 6'd2;
   localparam logic [5:0] S_PW_CHK = 6'd3;
   localparam logic [5:0] S_PW_WA = 6'd4;
   localparam logic [5:0] S_PW_SQ = 6'd5;
   localparam logic [5:0] S_PW_WB = 6'd6;
   localparam logic [5:0] S_FP    = 6'd7;
   localparam logic [5:0] S_SQ3A  = 6'd8;
   localparam logic [5:0] S_SQ3W  = 6'd9;
   localparam logic [5:0] S_S_LP  = 6'd10;
   localparam logic [5:0] S_Z_LP  = 6'd11;
   localparam logic [5:0] S_Z_CHK = 6'd12;
   localparam logic [5:0] S_TS_C  = 6'd13;
   localparam logic [5:0] S_TS_C2 = 6'd14;
   localparam logic [5:0] S_TS_T  = 6'd15;
   localparam logic [5:0] S_TS_T2 = 6'd16;
   localparam logic [5:0] S_TS_R  = 6'd17;
   localparam logic [5:0] S_TS_R2 = 6'd18;
   localparam logic [5:0] S_LOOP  = 6'd19;
   localparam logic [5:0] S_I_LP  = 6'd20;
   localparam logic [5:0] S_I_W   = 6'd21;
   localparam logic [5:0] S_B_LP  = 6'd22;
   localparam logic [5:0] S_B_W   = 6'd23;
   localparam logic [5:0] S_C_S   = 6'd24;
   localparam logic [5:0] S_C_W   = 6'd25;
   localparam logic [5:0] S_T_S   = 6'd26;
   localparam logic [5:0] S_T_W   = 6'd27;
   localparam logic [5:0] S_R_S   = 6'd28;
   localparam logic [5:0] S_R_W   = 6'd29;
   localparam logic [5:0] S_OUT   = 6'd30;

   logic [5:0] state_ff, state_in;
   logic [5:0] ret_ff, ret_in;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cmd          = '0;
      cmd.op       = mpsr_pkg::DP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = mpsr_pkg::DP_LOAD;
               state_in = S_RED;
            end
         end
         S_RED: begin
            if (sts.red_done) state_in = S_DISP;
            else cmd.op = mpsr_pkg::DP_RED_STEP;
         end
         // pick the operation once the operand sits below p
         S_DISP: begin
            if (sts.p_lt2 || (sts.op_sqrt && sts.n_zero)) begin
               cmd.op       = mpsr_pkg::DP_FIN_ROOT;
               cmd.root_sel = mpsr_pkg::ROOT_ZERO;
               state_in     = S_OUT;
            end else if (!sts.op_sqrt) begin
               cmd.op       = mpsr_pkg::DP_POW_INIT;
               cmd.base_sel = mpsr_pkg::BASE_N;
               cmd.exp_sel  = mpsr_pkg::EXP_IN;
               ret_in       = S_FP;
               state_in     = S_PW_CHK;
            end else if (sts.p_mod4_3) begin
               cmd.op       = mpsr_pkg::DP_POW_INIT;
               cmd.base_sel = mpsr_pkg::BASE_N;
               cmd.exp_sel  = mpsr_pkg::EXP_P4;
               ret_in       = S_SQ3A;
               state_in     = S_PW_CHK;
            end else begin
               cmd.op   = mpsr_pkg::DP_S_INIT;
               state_in = S_S_LP;
            end
         end
         // power loop: multiply on a set bit, then square
         S_PW_CHK: begin
            if (sts.e_zero) begin
               state_in = ret_ff;
            end else if (sts.e_lsb) begin
               cmd.op     = mpsr_pkg::DP_MUL;
               cmd.ma_sel = mpsr_pkg::MSRC_ACC;
               cmd.mb_sel = mpsr_pkg::MSRC_BASE;
               state_in   = S_PW_WA;
            end else begin
               cmd.op     = mpsr_pkg::DP_MUL;
               cmd.ma_sel = mpsr_pkg::MSRC_BASE;
               cmd.mb_sel = mpsr_pkg::MSRC_BASE;
               state_in   = S_PW_WB;
            end
         end
         S_PW_WA: begin
            if (sts.mul_done) begin
               cmd.op   = mpsr_pkg::DP_WB_ACC;
               state_in = S_PW_SQ;
            end
         end
         S_PW_SQ: begin
            cmd.op     = mpsr_pkg::DP_MUL;
            cmd.ma_sel = mpsr_pkg::MSRC_BASE;
            cmd.mb_sel = mpsr_pkg::MSRC_BASE;
            state_in   = S_PW_WB;
         end
         S_PW_WB: begin
            if (sts.mul_done) begin
               cmd.op   = mpsr_pkg::DP_WB_BASE;
               state_in = S_PW_CHK;
            end
         end
         S_FP: begin
            cmd.op   = mpsr_pkg::DP_FIN_POW;
            state_in = S_OUT;
         end
         // p = 3 mod 4: square the candidate and compare
         S_SQ3A: begin
            cmd.op     = mpsr_pkg::DP_MUL;
            cmd.ma_sel = mpsr_pkg::MSRC_ACC;
            cmd.mb_sel = mpsr_pkg::MSRC_ACC;
            state_in   = S_SQ3W;
         end
         S_SQ3W: begin
            if (sts.mul_done) begin
               if (sts.mul_eq_n) begin
                  cmd.op       = mpsr_pkg::DP_FIN_ROOT;
                  cmd.root_sel = mpsr_pkg::ROOT_ACC;
               end else begin
                  cmd.op = mpsr_pkg::DP_FIN_NONE;
               end
               state_in = S_OUT;
            end
         end
         // strip twos from p - 1
         S_S_LP: begin
            if (sts.q_even_nz) begin
               cmd.op = mpsr_pkg::DP_S_STEP;
            end else begin
               cmd.op   = mpsr_pkg::DP_Z_INIT;
               state_in = S_Z_LP;
            end
         end
         // non-residue search
         S_Z_LP: begin
            if (sts.cand_ok) begin
               cmd.op       = mpsr_pkg::DP_POW_INIT;
               cmd.base_sel = mpsr_pkg::BASE_CAND;
               cmd.exp_sel  = mpsr_pkg::EXP_PM1H;
               ret_in       = S_Z_CHK;
               state_in     = S_PW_CHK;
            end else begin
               state_in = S_TS_C;
            end
         end
         S_Z_CHK: begin
            if (sts.acc_eq_pm1) begin
               cmd.op   = mpsr_pkg::DP_Z_FOUND;
               state_in = S_TS_C;
            end else begin
               cmd.op   = mpsr_pkg::DP_Z_NEXT;
               state_in = S_Z_LP;
            end
         end
         S_TS_C: begin
            cmd.op       = mpsr_pkg::DP_POW_INIT;
            cmd.base_sel = mpsr_pkg::BASE_Z;
            cmd.exp_sel  = mpsr_pkg::EXP_Q;
            ret_in       = S_TS_C2;
            state_in     = S_PW_CHK;
         end
         S_TS_C2: begin
            cmd.op   = mpsr_pkg::DP_C_SET;
            state_in = S_TS_T;
         end
         S_TS_T: begin
            cmd.op       = mpsr_pkg::DP_POW_INIT;
            cmd.base_sel = mpsr_pkg::BASE_N;
            cmd.exp_sel  = mpsr_pkg::EXP_Q;
            ret_in       = S_TS_T2;
            state_in     = S_PW_CHK;
         end
         S_TS_T2: begin
            cmd.op   = mpsr_pkg::DP_T_SET;
            state_in = S_TS_R;
         end
         S_TS_R: begin
            cmd.op       = mpsr_pkg::DP_POW_INIT;
            cmd.base_sel = mpsr_pkg::BASE_N;
            cmd.exp_sel  = mpsr_pkg::EXP_QH;
            ret_in       = S_TS_R2;
            state_in     = S_PW_CHK;
         end
         S_TS_R2: begin
            cmd.op   = mpsr_pkg::DP_R_SET;
            state_in = S_LOOP;
         end
         // main Tonelli-Shanks iteration
         S_LOOP: begin
            if (sts.t_zero) begin
               cmd.op       = mpsr_pkg::DP_FIN_ROOT;
               cmd.root_sel = mpsr_pkg::ROOT_ZERO;
               state_in     = S_OUT;
            end else if (sts.t_one) begin
               cmd.op       = mpsr_pkg::DP_FIN_ROOT;
               cmd.root_sel = mpsr_pkg::ROOT_R;
               state_in     = S_OUT;
            end else begin
               cmd.op   = mpsr_pkg::DP_I_INIT;
               state_in = S_I_LP;
            end
         end
         S_I_LP: begin
            if (!sts.tt_one && sts.i_lt_mm) begin
               cmd.op     = mpsr_pkg::DP_MUL;
               cmd.ma_sel = mpsr_pkg::MSRC_TT;
               cmd.mb_sel = mpsr_pkg::MSRC_TT;
               state_in   = S_I_W;
            end else if (!sts.i_lt_mm) begin
               cmd.op   = mpsr_pkg::DP_FIN_NONE;
               state_in = S_OUT;
            end else begin
               cmd.op   = mpsr_pkg::DP_B_INIT;
               state_in = S_B_LP;
            end
         end
         S_I_W: begin
            if (sts.mul_done) begin
               cmd.op   = mpsr_pkg::DP_WB_TT;
               state_in = S_I_LP;
            end
         end
         S_B_LP: begin
            if (sts.j_cond) begin
               cmd.op     = mpsr_pkg::DP_MUL;
               cmd.ma_sel = mpsr_pkg::MSRC_B;
               cmd.mb_sel = mpsr_pkg::MSRC_B;
               state_in   = S_B_W;
            end else begin
               cmd.op   = mpsr_pkg::DP_MM_I;
               state_in = S_C_S;
            end
         end
         S_B_W: begin
            if (sts.mul_done) begin
               cmd.op   = mpsr_pkg::DP_WB_B;
               state_in = S_B_LP;
            end
         end
         S_C_S: begin
            cmd.op     = mpsr_pkg::DP_MUL;
            cmd.ma_sel = mpsr_pkg::MSRC_B;
            cmd.mb_sel = mpsr_pkg::MSRC_B;
            state_in   = S_C_W;
         end
         S_C_W: begin
            if (sts.mul_done) begin
               cmd.op   = mpsr_pkg::DP_WB_C;
               state_in = S_T_S;
            end
         end
         S_T_S: begin
            cmd.op     = mpsr_pkg::DP_MUL;
            cmd.ma_sel = mpsr_pkg::MSRC_T;
            cmd.mb_sel = mpsr_pkg::MSRC_C;
            state_in   = S_T_W;
         end
         S_T_W: begin
            if (sts.mul_done) begin
               cmd.op   = mpsr_pkg::DP_WB_T;
               state_in = S_R_S;
            end
         end
         S_R_S: begin
            cmd.op     = mpsr_pkg::DP_MUL;
            cmd.ma_sel = mpsr_pkg::MSRC_R;
            cmd.mb_sel = mpsr_pkg::MSRC_B;
            state_in   = S_R_W;
         end
         S_R_W: begin
            if (sts.mul_done) begin
               cmd.op   = mpsr_pkg::DP_WB_R;
               state_in = S_LOOP;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

[design/modular_pow_and_square_root_core.sv]
// Modular power and modular square root over a prime held in a register.
// Command channel: drive req_op, req_operand and req_exponent with start high;
// the transaction is taken at the edge where start is high and busy is low.
// req_op 0 raises the operand to the exponent, req_op 1 finds a square root
// (p mod 4 = 3 by the (p+1)/4 power, otherwise Tonelli-Shanks).
// Result: rsp_value, rsp_other_root, rsp_root_count and rsp_no_root are shown
// for exactly one cycle with rsp_valid high; the receiver cannot stall, so
// the result must be captured in that cycle. busy stays high from accept to
// the strobe cycle; one transaction is in flight at a time.
// Configuration: csr_data is written to the modulus when csr_valid is high
// (csr_ready is always high); write only while busy is low.
// Operand reduction shifts in one operand bit per cycle; modular multiplies
// then run in the shift-and-add unit, one multiplier bit per cycle, ending
// once the remaining multiplier bits (at most MOD_BITS) are zero. A power does
// one multiply per exponent bit plus one per set bit. Tonelli-Shanks adds the
// non-residue search and the order loops: several such powers and multiplies.
// Reset restores the modulus to 998244353 and returns the sequencer to idle.
module modular_pow_and_square_root_core #(
   parameter int MOD_BITS = 32,
   parameter int EXP_BITS = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [mpsr_pkg::FIELD_BITS-1:0] req_operand,
   input  logic [EXP_BITS-1:0]             req_exponent,
   output logic                            rsp_valid,
   output logic [mpsr_pkg::FIELD_BITS-1:0] rsp_value,
   output logic [mpsr_pkg::FIELD_BITS-1:0] rsp_other_root,
   output logic [1:0]                      rsp_root_count,
   output logic                            rsp_no_root,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mpsr_pkg::FIELD_BITS-1:0] csr_data
);

   mpsr_pkg::dp_cmd_type cmd;
   mpsr_pkg::dp_sts_type sts;

   assign csr_ready = 1'b1;

   mpsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   mpsr_dp #(
      .MOD_BITS (MOD_BITS),
      .EXP_BITS (EXP_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .req_op         (req_op),
      .req_operand    (req_operand),
      .req_exponent   (req_exponent),
      .rsp_value      (rsp_value),
      .rsp_other_root (rsp_other_root),
      .rsp_root_count (rsp_root_count),
      .rsp_no_root    (rsp_no_root)
   );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int FIELD_BITS = mpsr_pkg::FIELD_BITS;
   localparam int EXP_W = 63;
   localparam longint CYCLE_LIMIT = 6000000;

   typedef struct {
      logic [FIELD_BITS-1:0] value;
      logic [FIELD_BITS-1:0] other;
      logic [1:0]            count;
      logic                  none;
   } root_result_type;

   typedef struct {
      logic                  op;
      logic [FIELD_BITS-1:0] operand;
      logic [EXP_W-1:0]      exponent;
      bit                    fixed;
      root_result_type       res;
   } cmd_row_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   logic                  req_op = 0;
   logic [FIELD_BITS-1:0] req_operand = '0;
   logic [EXP_W-1:0]      req_exponent = '0;
   logic                  rsp_valid;
   logic [FIELD_BITS-1:0] rsp_value;
   logic [FIELD_BITS-1:0] rsp_other_root;
   logic [1:0]            rsp_root_count;
   logic                  rsp_no_root;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [FIELD_BITS-1:0] csr_data = '0;

   root_result_type pending_results[$];
   cmd_row_type     directed_rows[$];
   longint unsigned prime_reg;
   int             mismatches = 0;
   longint         cycles = 0;
   bit             idle_on;

   modular_pow_and_square_root_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_operand(req_operand), .req_exponent(req_exponent),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_other_root(rsp_other_root),
      .rsp_root_count(rsp_root_count), .rsp_no_root(rsp_no_root),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("modular_pow_and_square_root_core regression: fail");
         $finish;
      end
   end

   function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
      return (a * b) % m;
   endfunction

   function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned e,
                                               longint unsigned m);
      longint unsigned acc = 1;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, base, m);
         base = mod_mul(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // square root search; returns 0 when the operand is a non-residue
   function automatic bit mod_sqrt(longint unsigned n, longint unsigned m,
                                   output longint unsigned root);
      longint unsigned s, q, z, cand, tries, c, t, r, mm, i, tt, b, j;
      root = 0;
      if (n == 0) return 1;
      if (m[1:0] == 2'b11) begin
         r = mod_pow(n, (m >> 2) + 1, m);
         root = r;
         return mod_mul(r, r, m) == n;
      end
      s = 0;
      q = m - 1;
      while (q[0] == 0 && q != 0) begin
         q = q >> 1;
         s++;
      end
      z = 0;
      cand = 2;
      tries = 0;
      while (cand < m && tries < mpsr_pkg::SEARCH_LIMIT) begin
         if (mod_pow(cand, (m - 1) >> 1, m) == m - 1) begin
            z = cand;
            break;
         end
         cand++;
         tries++;
      end
      mm = s;
      c = mod_pow(z, q, m);
      t = mod_pow(n, q, m);
      r = mod_pow(n, (q >> 1) + 1, m);
      forever begin
         if (t == 0) begin
            root = 0;
            return 1;
         end
         if (t == 1) begin
            root = r;
            return 1;
         end
         i = 0;
         tt = t;
         while (tt != 1 && i < mm) begin
            tt = mod_mul(tt, tt, m);
            i++;
         end
         if (i >= mm) begin
            root = 0;
            return 0;
         end
         b = c;
         for (j = 0; j + i + 1 < mm; j++) b = mod_mul(b, b, m);
         mm = i;
         c = mod_mul(b, b, m);
         t = mod_mul(t, c, m);
         r = mod_mul(r, b, m);
      end
   endfunction

   function automatic root_result_type predict_result(logic op, logic [FIELD_BITS-1:0] operand,
                                                      logic [EXP_W-1:0] exponent);
      root_result_type res;
      longint unsigned p, n, r, neg;
      p = prime_reg;
      res.value = '0;
      res.other = '0;
      res.count = 2'd1;
      res.none = 1'b0;
      if (p >= 2) begin
         n = 64'(operand) % p;
         if (op == 1'b0) begin
            res.value = FIELD_BITS'(mod_pow(n, 64'(exponent), p));
         end else if (mod_sqrt(n, p, r)) begin
            neg = (r == 0) ? 0 : p - r;
            res.value = FIELD_BITS'(r);
            res.other = FIELD_BITS'(neg);
            res.count = (r == neg) ? 2'd1 : 2'd2;
         end else begin
            res.count = 2'd0;
            res.none = 1'b1;
         end
      end
      return res;
   endfunction

   // check each strobed result against the oldest expectation
   always @(posedge clock) begin
      root_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result value=%0d", rsp_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_value !== want.value || rsp_other_root !== want.other ||
                rsp_root_count !== want.count || rsp_no_root !== want.none) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch p=%0d: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           prime_reg, want.value, want.other, want.count, want.none,
                           rsp_value, rsp_other_root, rsp_root_count, rsp_no_root);
            end
         end
      end
   end

   task automatic write_modulus(logic [FIELD_BITS-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      prime_reg = 64'(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // issue one transaction and queue its expected result
   task automatic send_cmd(cmd_row_type row);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      start = 1'b1;
      req_op = row.op;
      req_operand = row.operand;
      req_exponent = row.exponent;
      do @(posedge clock); while (busy);
      pending_results.push_back(row.fixed ? row.res
                                : predict_result(row.op, row.operand, row.exponent));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic add_row(int op, longint unsigned operand, longint unsigned e,
                          int fixed, longint unsigned v, longint unsigned o,
                          int c, int nr);
      cmd_row_type row;
      row.op = 1'(op);
      row.operand = FIELD_BITS'(operand);
      row.exponent = EXP_W'(e);
      row.fixed = (fixed != 0);
      row.res.value = FIELD_BITS'(v);
      row.res.other = FIELD_BITS'(o);
      row.res.count = 2'(c);
      row.res.none = 1'(nr);
      directed_rows.push_back(row);
   endtask

   function automatic cmd_row_type random_cmd(longint unsigned p);
      cmd_row_type     row;
      longint unsigned x;
      int              pick;
      row.fixed = 0;
      row.op = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 7);
      x = 64'($urandom) % p;
      if (pick == 0) row.operand = $urandom;
      else if (pick == 1) row.operand = FIELD_BITS'(($urandom_range(0, 1) != 0) ? p - 1 : 0);
      else if (row.op && pick < 6) row.operand = FIELD_BITS'(mod_mul(x, x, p));
      else row.operand = FIELD_BITS'(64'($urandom) % p);
      case ($urandom_range(0, 3))
         0: row.exponent = EXP_W'({$urandom, $urandom});
         1: row.exponent = EXP_W'($urandom);
         default: row.exponent = EXP_W'($urandom_range(0, 64));
      endcase
      return row;
   endfunction

   initial begin
      longint unsigned phase_mod[13];
      int              phase_cnt[13];
      phase_mod = '{2, 3, 5, 13, 17, 97, 21, 15, 65537,
                    4294967291, 4294967295, 998244353, 7};
      phase_cnt = '{10, 10, 12, 14, 14, 14, 10, 8, 12, 10, 8, 6, 12};
      prime_reg = 64'(mpsr_pkg::MODULUS_RESET);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idle_on = 1;

      // directed rows under the reset modulus
      add_row(0, 0, 0, 1, 1, 0, 1, 0);
      add_row(0, 5, 0, 1, 1, 0, 1, 0);
      add_row(0, 0, 7, 1, 0, 0, 1, 0);
      add_row(0, 1, '1, 1, 1, 0, 1, 0);
      add_row(0, 32'hFFFF_FFFE, '1, 0, 0, 0, 0, 0);
      add_row(0, 3, 998244352, 0, 0, 0, 0, 0);
      add_row(0, 998244352, 63'h2AAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0);
      add_row(1, 0, 0, 1, 0, 0, 1, 0);
      add_row(1, 1, 0, 0, 0, 0, 0, 0);
      add_row(1, 3, 0, 1, 0, 0, 0, 1);
      add_row(1, 4, 0, 0, 0, 0, 0, 0);
      add_row(1, 32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0);
      add_row(1, 9, '1, 0, 0, 0, 0, 0);
      add_row(1, 998244352, 0, 0, 0, 0, 0, 0);
      foreach (directed_rows[k]) send_cmd(directed_rows[k]);

      // random phases, each under its own modulus
      for (int ph = 0; ph < 13; ph++) begin
         // hold off until every expected result has come
         wait (pending_results.size() == 0);
         repeat (4) @(negedge clock);
         write_modulus(FIELD_BITS'(phase_mod[ph]));
         idle_on = (ph == 12) ? 0 : ($urandom_range(0, 3) != 0);
         for (int k = 0; k < phase_cnt[ph]; k++) send_cmd(random_cmd(phase_mod[ph]));
      end

      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("modular_pow_and_square_root_core regression: pass");
      end else begin
         $display("modular_pow_and_square_root_core regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
design/mpsr_pkg.sv
design/mpsr_mulmod.sv
design/mpsr_dp.sv
design/mpsr_ctrl.sv
design/modular_pow_and_square_root_core.sv
test/tb.sv
